// ----- sv/ptc_pkg.sv -----
// Shared types, constants and helper functions of the per-name traffic counter table.
// Used by ptc_front, ptc_back, the top level and the testbench; depends on nothing else.
`default_nettype none
package ptc_pkg;

  localparam int NAME_BYTES = 16;
  localparam int READ_IDX_W = 10;
  localparam int LEN_W      = 31;
  localparam int STATUS_W   = 3;

  localparam logic [31:0] HASH_INIT = 32'hDEADBEEF;
  localparam logic [31:0] HASH_MULT = 32'h61C88647;

  localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_READ_OK  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ_NONE = 3'd4;

  // One request as it travels from the front end to the back end.
  typedef struct packed {
    logic                  action;
    logic [63:0]           name_high;
    logic [63:0]           name_low;
    logic                  is_send;
    logic [LEN_W-1:0]      byte_length;
    logic [31:0]           user_id;
    logic [READ_IDX_W-1:0] read_index;
  } ptc_item_t;

  // One table row; the lowest field sits in the lowest bits.
  typedef struct packed {
    logic [63:0] sent_total;
    logic [63:0] received_total;
    logic [31:0] user_id;
    logic [63:0] name_high;
    logic [63:0] name_low;
  } ptc_row_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage
`default_nettype wire

// ----- sv/ptc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the row store, the chain links and the bucket heads.
`default_nettype none
module ptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/ptc_front.sv -----
// Front end: takes a beat, trims the name at its first zero byte and, for an account
// beat, hashes it to a bucket one mixing step per cycle. Depends on ptc_pkg.
`default_nettype none
module ptc_front import ptc_pkg::*; #(
  parameter int HASH_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ptc_item_t            in_item_i,
  output logic                      push_o,
  output ptc_item_t                 push_item_o,
  output logic [HASH_BITS-1:0]      push_bucket_o,
  input  wire logic                 push_ready_i
);

  localparam logic [3:0] S_M0 = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3;
  localparam logic [3:0] S_M4 = 4'd4, S_M5 = 4'd5, S_W3 = 4'd6, S_F0 = 4'd7;
  localparam logic [3:0] S_F1 = 4'd8, S_F2 = 4'd9, S_F3 = 4'd10, S_F4 = 4'd11;
  localparam logic [3:0] S_F5 = 4'd12, S_F6 = 4'd13, S_MUL = 4'd14, S_PUSH = 4'd15;

  logic        busy_q, busy_d;
  logic [3:0]  step_q, step_d;
  ptc_item_t   item_q;
  logic [31:0] a_q, b_q, c_q, a_d, b_d, c_d;
  logic [127:0] raw, norm;
  logic [4:0]  nlen;
  logic        found;
  logic [31:0] seed;
  logic        accept;
  ptc_item_t   item_n;

  assign in_ready_o = en_i && !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // The name ends at its first zero byte; everything after it reads as zero.
  always_comb begin
    raw   = {in_item_i.name_high, in_item_i.name_low};
    nlen  = 5'd16;
    found = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (!found && raw[i*8 +: 8] == 8'h00) begin
        nlen  = 5'(i);
        found = 1'b1;
      end
    end
    for (int i = 0; i < NAME_BYTES; i++) begin
      norm[i*8 +: 8] = (5'(i) < nlen) ? raw[i*8 +: 8] : 8'h00;
    end
    seed             = HASH_INIT + 32'(nlen);
    item_n           = in_item_i;
    item_n.name_low  = norm[63:0];
    item_n.name_high = norm[127:64];
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    step_d = step_q + 4'd1;
    busy_d = busy_q;
    case (step_q)
      S_M0: begin a_d = (a_q - c_q) ^ rotl(c_q, 4);  c_d = c_q + b_q; end
      S_M1: begin b_d = (b_q - a_q) ^ rotl(a_q, 6);  a_d = a_q + c_q; end
      S_M2: begin c_d = (c_q - b_q) ^ rotl(b_q, 8);  b_d = b_q + a_q; end
      S_M3: begin a_d = (a_q - c_q) ^ rotl(c_q, 16); c_d = c_q + b_q; end
      S_M4: begin b_d = (b_q - a_q) ^ rotl(a_q, 19); a_d = a_q + c_q; end
      S_M5: begin c_d = (c_q - b_q) ^ rotl(b_q, 4);  b_d = b_q + a_q; end
      S_W3: a_d = a_q + item_q.name_high[63:32];
      S_F0: c_d = (c_q ^ b_q) - rotl(b_q, 14);
      S_F1: a_d = (a_q ^ c_q) - rotl(c_q, 11);
      S_F2: b_d = (b_q ^ a_q) - rotl(a_q, 25);
      S_F3: c_d = (c_q ^ b_q) - rotl(b_q, 16);
      S_F4: a_d = (a_q ^ c_q) - rotl(c_q, 4);
      S_F5: b_d = (b_q ^ a_q) - rotl(a_q, 14);
      S_F6: c_d = (c_q ^ b_q) - rotl(b_q, 24);
      S_MUL: c_d = c_q * HASH_MULT;
      S_PUSH: begin
        step_d = S_PUSH;
        if (push_ready_i) begin
          busy_d = 1'b0;
        end
      end
      default: step_d = S_PUSH;
    endcase
    if (accept) begin
      busy_d = 1'b1;
      a_d    = seed + ((nlen != 5'd0) ? norm[31:0]  : 32'd0);
      b_d    = seed + ((nlen != 5'd0) ? norm[63:32] : 32'd0);
      c_d    = seed + ((nlen != 5'd0) ? norm[95:64] : 32'd0);
      if (in_item_i.action) begin
        step_d = S_PUSH;
      end else if (nlen > 5'd12) begin
        step_d = S_M0;
      end else if (nlen != 5'd0) begin
        step_d = S_F0;
      end else begin
        step_d = S_MUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= S_PUSH;
    end else begin
      busy_q <= busy_d;
      if (busy_q || accept) begin
        step_q <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    if (accept) begin
      item_q <= item_n;
    end
  end

  assign push_o        = busy_q && (step_q == S_PUSH);
  assign push_item_o   = item_q;
  assign push_bucket_o = c_q[31 -: HASH_BITS];

endmodule
`default_nettype wire

// ----- sv/ptc_fifo.sv -----
// Short queue that decouples the hashing front end from the table back end.
// Stands alone apart from its parameters.
`default_nettype none
module ptc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ptc_back.sv -----
// Back end: clears the bucket heads after reset, walks hash chains, updates or
// inserts rows and serves listing reads. Depends on ptc_pkg and ptc_ram.
`default_nettype none
module ptc_back import ptc_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int HASH_BITS     = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  output logic                       ready_o,
  input  wire logic                  req_valid_i,
  input  wire ptc_item_t             req_item_i,
  input  wire logic [HASH_BITS-1:0]  req_bucket_i,
  output logic                       req_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STATUS_W-1:0]        out_status_o,
  output ptc_row_t                   out_row_o
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int LINK_W  = IDX_W + 1;
  localparam int CMP_W   = (LINK_W > READ_IDX_W) ? LINK_W : READ_IDX_W;
  localparam int BUCKETS = 1 << HASH_BITS;

  localparam logic [2:0] B_CLEAR = 3'd0, B_IDLE = 3'd1, B_HEAD = 3'd2;
  localparam logic [2:0] B_WALK  = 3'd3, B_CMP  = 3'd4, B_READ = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [HASH_BITS-1:0] clr_q;
  logic [LINK_W-1:0]    count_q, link_q, head_q, steps_q;
  ptc_item_t            cur_q;
  logic [HASH_BITS-1:0] bucket_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  ptc_row_t             out_row_q;

  logic                 row_we, row_re, chn_we, bkt_we, bkt_re;
  logic [IDX_W-1:0]     row_waddr, row_raddr;
  ptc_row_t             row_wdata, row_rdata;
  logic [LINK_W-1:0]    chn_rdata, bkt_rdata, bkt_wdata;
  logic [HASH_BITS-1:0] bkt_waddr;
  logic [CMP_W-1:0]     rd_pos;
  logic                 link_ok, key_hit, table_full;
  logic [63:0]          len64;

  assign ready_o    = (state_q != B_CLEAR);
  assign req_pop_o  = (state_q == B_IDLE) && req_valid_i && !out_valid_q;
  assign rd_pos     = CMP_W'(count_q) - CMP_W'(1) - CMP_W'(req_item_i.read_index);
  assign link_ok    = (link_q != '0) && (link_q <= LINK_W'(TABLE_ENTRIES)) && (steps_q < count_q);
  assign key_hit    = (row_rdata.name_low == cur_q.name_low) &&
                      (row_rdata.name_high == cur_q.name_high);
  assign table_full = (count_q >= LINK_W'(TABLE_ENTRIES));
  assign len64      = 64'(cur_q.byte_length);

  always_comb begin
    state_d   = state_q;
    row_we    = 1'b0;
    row_re    = 1'b0;
    chn_we    = 1'b0;
    bkt_we    = 1'b0;
    bkt_re    = 1'b0;
    row_waddr = IDX_W'(link_q - LINK_W'(1));
    row_raddr = IDX_W'(link_q - LINK_W'(1));
    row_wdata = row_rdata;
    bkt_waddr = bucket_q;
    bkt_wdata = count_q + LINK_W'(1);
    case (state_q)
      B_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_q;
        bkt_wdata = '0;
        if (clr_q == HASH_BITS'(BUCKETS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        row_raddr = rd_pos[IDX_W-1:0];
        if (req_pop_o) begin
          if (req_item_i.action) begin
            if (CMP_W'(req_item_i.read_index) < CMP_W'(count_q)) begin
              row_re  = 1'b1;
              state_d = B_READ;
            end
          end else begin
            bkt_re  = 1'b1;
            state_d = B_HEAD;
          end
        end
      end
      B_HEAD: state_d = B_WALK;
      B_WALK: begin
        if (link_ok) begin
          row_re  = 1'b1;
          state_d = B_CMP;
        end else begin
          state_d = B_IDLE;
          if (!table_full) begin
            row_we                   = 1'b1;
            chn_we                   = 1'b1;
            bkt_we                   = 1'b1;
            row_waddr                = count_q[IDX_W-1:0];
            row_wdata.name_low       = cur_q.name_low;
            row_wdata.name_high      = cur_q.name_high;
            row_wdata.user_id        = cur_q.user_id;
            row_wdata.sent_total     = cur_q.is_send ? len64 : 64'd0;
            row_wdata.received_total = cur_q.is_send ? 64'd0 : len64;
          end
        end
      end
      B_CMP: begin
        if (key_hit) begin
          row_we  = 1'b1;
          state_d = B_IDLE;
          if (cur_q.is_send) begin
            row_wdata.sent_total = row_rdata.sent_total + len64;
          end else begin
            row_wdata.received_total = row_rdata.received_total + len64;
          end
        end else begin
          state_d = B_WALK;
        end
      end
      B_READ: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + HASH_BITS'(1);
      end
      if (state_q == B_WALK && !link_ok && !table_full) begin
        count_q <= count_q + LINK_W'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end else if ((req_pop_o && req_item_i.action && state_d == B_IDLE) ||
                   (state_q == B_WALK && !link_ok) ||
                   (state_q == B_CMP && key_hit) || (state_q == B_READ)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      cur_q    <= req_item_i;
      bucket_q <= req_bucket_i;
      out_row_q    <= '0;
      out_status_q <= STAT_READ_NONE;
    end
    if (state_q == B_HEAD) begin
      link_q  <= bkt_rdata;
      head_q  <= bkt_rdata;
      steps_q <= '0;
    end
    if (state_q == B_CMP && !key_hit) begin
      link_q  <= chn_rdata;
      steps_q <= steps_q + LINK_W'(1);
    end
    if (state_q == B_WALK && !link_ok) begin
      out_status_q <= table_full ? STAT_DROPPED : STAT_INSERTED;
    end
    if (state_q == B_CMP && key_hit) begin
      out_status_q <= STAT_UPDATED;
    end
    if (state_q == B_READ) begin
      out_status_q <= STAT_READ_OK;
      out_row_q    <= row_rdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_row_o    = out_row_q;

  ptc_ram #(.WIDTH($bits(ptc_row_t)), .DEPTH(TABLE_ENTRIES)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  ptc_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_ENTRIES)) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (chn_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (head_q),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (chn_rdata)
  );

  ptc_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (req_bucket_i),
    .rdata_o (bkt_rdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LINK_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");
  a_pop_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |-> !out_valid_q)
    else $error("request started while a result is pending");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CLEAR |-> !req_pop_o && !out_valid_q)
    else $error("activity during bucket clearing");
  a_cmp_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CMP |-> link_q != '0 && $past(state_q) == B_WALK)
    else $error("compare without a valid link");

endmodule
`default_nettype wire

// ----- sv/per_name_traffic_counter_table.sv -----
// Top level of the per-name traffic counter table: front end, queue and back end.
// Depends on ptc_pkg, ptc_front, ptc_fifo, ptc_back and ptc_ram.
//
// This block keeps up to TABLE_ENTRIES rows, each keyed by a 16-byte name that is
// cut at its first zero byte, holding the owner user id and 64-bit receive and send
// byte counters that wrap. A beat with tuser 0 accounts traffic: the name is hashed
// into one of 2^HASH_BITS buckets and the bucket's chain is walked; a hit adds
// byte_length to the chosen counter (status 0), a miss inserts a new row (status 1)
// or, with the table full, is dropped (status 2). A beat with tuser 1 reads row
// read_index of the listing, newest row first (status 3, or 4 past the end). Every
// input beat gives exactly one output beat, in order; account results carry zeros.
// The front end trims the name and, for an account beat, hashes it, one mixing step a
// cycle, and a two-entry queue lets it take the next beat while the back end works.
// For an account beat the back end reads the bucket head, then walks the chain through
// B_WALK and B_CMP for every row it compares, bounded by the row count; a read of a
// stored row passes through B_READ and a read past the end is answered from B_IDLE.
// A new request starts only once the previous result has left the output register.
// After reset the block clears the bucket head memory, one bucket a cycle, so
// s_axis_tready stays low until every bucket has been cleared.
`default_nettype none
module per_name_traffic_counter_table import ptc_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int HASH_BITS     = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // name_low, name_high, is_send, byte_length, user_id, read_index, zero pad
  input  wire logic [207:0] s_axis_tdata,
  // action
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // entry_name_low, entry_name_high, entry_user_id, received_total, sent_total
  output logic      [287:0] m_axis_tdata,
  // status
  output logic      [2:0]   m_axis_tuser
);

  ptc_item_t            in_item, push_item, q_item;
  logic                 back_ready, push, q_full, q_valid, q_pop;
  logic [HASH_BITS-1:0] push_bucket, q_bucket;
  ptc_row_t             out_row;

  always_comb begin
    in_item.action      = s_axis_tuser;
    in_item.name_low    = s_axis_tdata[63:0];
    in_item.name_high   = s_axis_tdata[127:64];
    in_item.is_send     = s_axis_tdata[128];
    in_item.byte_length = s_axis_tdata[159:129];
    in_item.user_id     = s_axis_tdata[191:160];
    in_item.read_index  = s_axis_tdata[201:192];
  end

  ptc_front #(.HASH_BITS(HASH_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (back_ready),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_item_i     (in_item),
    .push_o        (push),
    .push_item_o   (push_item),
    .push_bucket_o (push_bucket),
    .push_ready_i  (!q_full)
  );

  ptc_fifo #(.WIDTH($bits(ptc_item_t) + HASH_BITS), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .wdata_i ({push_bucket, push_item}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o ({q_bucket, q_item})
  );

  ptc_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .HASH_BITS(HASH_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ready_o      (back_ready),
    .req_valid_i  (q_valid),
    .req_item_i   (q_item),
    .req_bucket_i (q_bucket),
    .req_pop_o    (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_row_o    (out_row)
  );

  assign m_axis_tdata = out_row;

endmodule
`default_nettype wire

// ----- bench/per_name_traffic_counter_table_tb.sv -----
// Self-checking testbench for the per-name traffic counter table.
// Depends on ptc_pkg and per_name_traffic_counter_table; it keeps its own copy of
// the table, predicts every result beat and compares it field by field.
`timescale 1ns / 100ps
`default_nettype none
module per_name_traffic_counter_table_tb;
  import ptc_pkg::*;

  localparam int ROWS      = 1024;
  localparam int HBITS     = 8;
  localparam int RAND_GOAL = 1250;
  localparam int CYC_LIMIT = 1000000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    ptc_row_t            row;
  } table_answer_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  per_name_traffic_counter_table i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table.
  ptc_row_t    shadow_rows [ROWS];
  int unsigned shadow_next [ROWS];
  int unsigned shadow_heads[1 << HBITS];
  int unsigned shadow_count;

  ptc_item_t     pending_beats[$];
  table_answer_t awaited_answers[$];
  logic [127:0]  known_names[$];
  int            known_lens[$];

  int unsigned total_beats, beats_taken, answers_seen, errors, cycles;
  int unsigned n_upd, n_ins, n_drop, n_rd_ok, n_rd_none;

  function automatic logic [31:0] rot32(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Cut the name at its first zero byte; returns the trimmed name and its length.
  function automatic void trim_name(input logic [127:0] raw, output logic [127:0] nm,
                                    output int len);
    len = 16;
    for (int i = 0; i < 16; i++)
      if (len == 16 && raw[i*8 +: 8] == 8'h00) len = i;
    nm = raw;
    for (int i = 0; i < 16; i++)
      if (i >= len) nm[i*8 +: 8] = 8'h00;
  endfunction

  // Bucket hash: lookup3 over up to four words, folded by a golden-ratio multiply.
  function automatic int unsigned bucket_of_name(logic [127:0] nm, int len);
    logic [31:0] a, b, c, p;
    a = HASH_INIT + len;
    b = a;
    c = a;
    if (len > 12) begin
      a += nm[31:0]; b += nm[63:32]; c += nm[95:64];
      a -= c; a ^= rot32(c, 4);  c += b;
      b -= a; b ^= rot32(a, 6);  a += c;
      c -= b; c ^= rot32(b, 8);  b += a;
      a -= c; a ^= rot32(c, 16); c += b;
      b -= a; b ^= rot32(a, 19); a += c;
      c -= b; c ^= rot32(b, 4);  b += a;
      a += nm[127:96];
    end else if (len > 0) begin
      a += nm[31:0]; b += nm[63:32]; c += nm[95:64];
    end
    if (len > 0) begin
      c ^= b; c -= rot32(b, 14);
      a ^= c; a -= rot32(c, 11);
      b ^= a; b -= rot32(a, 25);
      c ^= b; c -= rot32(b, 16);
      a ^= c; a -= rot32(c, 4);
      b ^= a; b -= rot32(a, 14);
      c ^= b; c -= rot32(b, 24);
    end
    p = c * HASH_MULT;
    return p[31:32-HBITS];
  endfunction

  // Applies one request to the shadow table and returns the answer it gives.
  function automatic table_answer_t table_update(ptc_item_t it);
    table_answer_t ans;
    logic [127:0]  nm;
    int            len;
    int unsigned   bkt, link, steps, e;
    ans = '0;
    if (it.action) begin
      if (it.read_index < shadow_count) begin
        ans.status = STAT_READ_OK;
        ans.row    = shadow_rows[shadow_count - 1 - it.read_index];
      end else begin
        ans.status = STAT_READ_NONE;
      end
      return ans;
    end
    trim_name({it.name_high, it.name_low}, nm, len);
    bkt   = bucket_of_name(nm, len);
    link  = shadow_heads[bkt];
    steps = 0;
    while (link != 0 && link <= ROWS && steps < shadow_count) begin
      e = link - 1;
      if ({shadow_rows[e].name_high, shadow_rows[e].name_low} == nm) begin
        if (it.is_send) shadow_rows[e].sent_total += 64'(it.byte_length);
        else shadow_rows[e].received_total += 64'(it.byte_length);
        ans.status = STAT_UPDATED;
        return ans;
      end
      link = shadow_next[e];
      steps++;
    end
    if (shadow_count >= ROWS) begin
      ans.status = STAT_DROPPED;
      return ans;
    end
    e = shadow_count;
    shadow_rows[e].name_low       = nm[63:0];
    shadow_rows[e].name_high      = nm[127:64];
    shadow_rows[e].user_id        = it.user_id;
    shadow_rows[e].sent_total     = it.is_send ? 64'(it.byte_length) : 64'd0;
    shadow_rows[e].received_total = it.is_send ? 64'd0 : 64'(it.byte_length);
    shadow_next[e]   = shadow_heads[bkt];
    shadow_heads[bkt] = e + 1;
    shadow_count     = e + 1;
    ans.status = STAT_INSERTED;
    return ans;
  endfunction

  task automatic queue_beat(logic act, logic [127:0] raw, logic snd, logic [30:0] blen,
                            logic [31:0] uid, logic [9:0] ridx);
    ptc_item_t     it;
    table_answer_t ans;
    it.action      = act;
    it.name_low    = raw[63:0];
    it.name_high   = raw[127:64];
    it.is_send     = snd;
    it.byte_length = blen;
    it.user_id     = uid;
    it.read_index  = ridx;
    ans = table_update(it);
    case (ans.status)
      STAT_UPDATED:  n_upd++;
      STAT_INSERTED: n_ins++;
      STAT_DROPPED:  n_drop++;
      STAT_READ_OK:  n_rd_ok++;
      default:       n_rd_none++;
    endcase
    pending_beats.push_back(it);
    awaited_answers.push_back(ans);
  endtask

  // Builds a name of the given length: nonzero bytes, a zero terminator when it is
  // shorter than 16 bytes and, at random, garbage after it that the block must ignore.
  function automatic logic [127:0] spell_name(logic [127:0] base, int len, bit fresh);
    logic [127:0] raw;
    raw = base;
    for (int i = 0; i < 16; i++) begin
      if (i < len) begin
        if (fresh) raw[i*8 +: 8] = 8'($urandom_range(255, 1));
      end else if (i == len) begin
        raw[i*8 +: 8] = 8'h00;
      end else begin
        raw[i*8 +: 8] = $urandom_range(1) ? 8'($urandom) : 8'h00;
      end
    end
    return raw;
  endfunction

  task automatic account_random(bit fresh);
    logic [127:0] raw, nm;
    int           len, k;
    if (fresh || known_names.size() == 0) begin
      len = $urandom_range(3) == 0 ? $urandom_range(16) : $urandom_range(16, 4);
      raw = spell_name('0, len, 1'b1);
      trim_name(raw, nm, len);
      known_names.push_back(nm);
      known_lens.push_back(len);
    end else begin
      k   = $urandom_range(known_names.size() - 1);
      raw = spell_name(known_names[k], known_lens[k], 1'b0);
    end
    queue_beat(1'b0, raw, 1'($urandom), 31'($urandom), $urandom, 10'($urandom));
  endtask

  // Stimulus: a directed opening, then random traffic until the table has
  // overflowed for a while, capped at RAND_GOAL + 100 random beats.
  initial begin
    int unsigned rnd, after_full;
    shadow_count = 0;
    foreach (shadow_heads[i]) shadow_heads[i] = 0;
    foreach (shadow_rows[i]) shadow_rows[i] = '0;
    foreach (shadow_next[i]) shadow_next[i] = 0;

    // Reads of an empty table, at both ends of the index range.
    queue_beat(1'b1, '1, 1'b1, '1, '1, 10'd0);
    queue_beat(1'b1, '0, 1'b0, '0, '0, 10'd1023);
    // The empty name, then the same empty name with garbage behind its terminator.
    queue_beat(1'b0, '0, 1'b0, 31'd0, 32'd0, 10'd0);
    queue_beat(1'b0, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00}, 1'b1,
               '1, '1, '1);
    // A full 16-byte name with no terminator, both counters, extreme lengths.
    queue_beat(1'b0, '1, 1'b1, '1, '1, '1);
    queue_beat(1'b0, '1, 1'b0, '1, 32'd0, '0);
    queue_beat(1'b0, '1, 1'b1, 31'd1, 32'd7, '0);
    // Names of 12 and 13 bytes sit on either side of the hash's long-name path.
    queue_beat(1'b0, {64'h0000_0000_0C0B_0A09, 64'h0807_0605_0403_0201}, 1'b0,
               31'd100, 32'h1234_5678, '0);
    queue_beat(1'b0, {64'h0000_000D_0C0B_0A09, 64'h0807_0605_0403_0201}, 1'b1,
               31'd200, 32'h8765_4321, '0);
    // An 8-byte name whose terminator is the first byte of the high word; garbage after it.
    queue_beat(1'b0, {64'hABCD_EF01_2345_6700, 64'h4142_4344_4546_4748}, 1'b0,
               31'd5, 32'd42, '0);
    queue_beat(1'b0, {64'h0000_0000_0000_0000, 64'h4142_4344_4546_4748}, 1'b1,
               31'd6, 32'd43, '0);
    queue_beat(1'b0, {64'h0, 64'h0000_0000_0000_0061}, 1'b0, 31'd9, 32'd1, '0);
    for (int i = 0; i < 8; i++)
      queue_beat(1'b1, '0, 1'b0, '0, '0, 10'(i));
    queue_beat(1'b1, '1, 1'b1, '1, '1, 10'd1023);

    rnd = 0;
    after_full = 0;
    while ((rnd < RAND_GOAL || after_full < 100) && rnd < RAND_GOAL + 100) begin
      if ($urandom_range(99) < 8)
        queue_beat(1'b1, {$urandom, $urandom, $urandom, $urandom}, 1'($urandom),
                   31'($urandom), $urandom,
                   $urandom_range(1) ? 10'($urandom_range(shadow_count + 2)) : 10'($urandom));
      else
        account_random($urandom_range(99) < (shadow_count < ROWS ? 97 : 30));
      if (shadow_count >= ROWS) after_full++;
      rnd++;
    end
    total_beats = pending_beats.size();

    wait (beats_taken == total_beats && awaited_answers.size() == 0);
    repeat (64) @(posedge clk_i);
    $display("Ran %0d beats: %0d inserted, %0d updated, %0d dropped on a full table,",
             total_beats, n_ins, n_upd, n_drop);
    $display("%0d reads of a row and %0d reads past the end; %0d mismatches.",
             n_rd_ok, n_rd_none, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Idle ratios in percent: the receiver idles more in the first third, the sender in the second, then neither.
  function automatic int unsigned send_idle_pct();
    if (beats_taken < total_beats / 3) return 34;
    if (beats_taken < 2 * total_beats / 3) return 47;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (beats_taken < total_beats / 3) return 47;
    if (beats_taken < 2 * total_beats / 3) return 34;
    return 0;
  endfunction

  // Driver: presents the next pending beat once the previous one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) beats_taken <= beats_taken + 1;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          ptc_item_t it;
          it = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.action;
          s_axis_tdata  <= {6'd0, it.read_index, it.user_id, it.byte_length, it.is_send,
                            it.name_high, it.name_low};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every taken result beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_idle_pct();
      if (m_axis_tvalid && m_axis_tready) begin
        answers_seen <= answers_seen + 1;
        if (awaited_answers.size() == 0) begin
          $error("result beat with nothing expected: status %0d", m_axis_tuser);
          errors++;
        end else begin
          table_answer_t exp_ans;
          ptc_row_t      got;
          exp_ans = awaited_answers.pop_front();
          got     = m_axis_tdata;
          if (m_axis_tuser !== exp_ans.status) begin
            $error("status: expected %0d, got %0d", exp_ans.status, m_axis_tuser);
            errors++;
          end
          if (got.name_low !== exp_ans.row.name_low) begin
            $error("entry_name_low: expected %h, got %h", exp_ans.row.name_low,
                   got.name_low);
            errors++;
          end
          if (got.name_high !== exp_ans.row.name_high) begin
            $error("entry_name_high: expected %h, got %h", exp_ans.row.name_high,
                   got.name_high);
            errors++;
          end
          if (got.user_id !== exp_ans.row.user_id) begin
            $error("entry_user_id: expected %h, got %h", exp_ans.row.user_id,
                   got.user_id);
            errors++;
          end
          if (got.received_total !== exp_ans.row.received_total) begin
            $error("received_total: expected %h, got %h", exp_ans.row.received_total,
                   got.received_total);
            errors++;
          end
          if (got.sent_total !== exp_ans.row.sent_total) begin
            $error("sent_total: expected %h, got %h", exp_ans.row.sent_total,
                   got.sent_total);
            errors++;
          end
        end
      end
    end
  end

  // Reset once at the start; a cycle counter guards against a hang.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               awaited_answers.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    beats_taken  = 0;
    answers_seen = 0;
    errors       = 0;
    cycles       = 0;
  end

endmodule
`default_nettype wire

// ----- per_name_traffic_counter_table.f -----
sv/ptc_pkg.sv
sv/ptc_ram.sv
sv/ptc_front.sv
sv/ptc_fifo.sv
sv/ptc_back.sv
sv/per_name_traffic_counter_table.sv
bench/per_name_traffic_counter_table_tb.sv
